// ===== rtl/mcp_pkg.sv =====
// Shared types and constants for the MQTT CONNECT parser.
`default_nettype none

package mcp_pkg;

    localparam logic [7:0] CONNACK_TYPE = 8'h20;
    localparam logic [7:0] CONNACK_LEN  = 8'h02;
    localparam logic [7:0] CONNACK_RSVD = 8'h00;
    localparam logic [3:0] TYPE_CONNECT = 4'h1;
    localparam logic [7:0] TYPE_MASK    = 8'hF0;

    localparam logic       CODE_ACCEPTED = 1'b0;
    localparam logic       CODE_BAD_NAME = 1'b1;

    // Entry zero holds the first expected character of the protocol name.
    localparam logic [3:0][7:0] NAME_CHARS = {8'h54, 8'h54, 8'h51, 8'h4D};
    localparam logic [15:0]     NAME_LEN   = 16'd4;

    localparam logic [2:0] VARINT_MAX = 3'd4;
    localparam int         STR_COUNT  = 5;
    localparam logic [2:0] STR_LAST   = 3'(STR_COUNT - 1);
    localparam logic [1:0] BEAT_LAST  = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_VARINT,
        PH_NAME_HI,
        PH_NAME_LO,
        PH_NAME_BODY,
        PH_LEVEL,
        PH_FLAGS,
        PH_KA_HI,
        PH_KA_LO,
        PH_STR_HI,
        PH_STR_LO,
        PH_STR_BODY
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_start;
    } t_in;

    typedef struct packed {
        logic [7:0]  reply_byte;
        logic        reply_last;
        logic        return_code;
        logic [7:0]  proto_lvl;
        logic [7:0]  flag_bits;
        logic [15:0] alive_secs;
    } t_out;

    // One pending CONNACK, handed from the parser to the reply serializer.
    typedef struct packed {
        logic        code;
        logic [7:0]  level;
        logic [7:0]  flags;
        logic [15:0] alive_secs;
    } t_event;

endpackage

`default_nettype wire

// ===== rtl/mcp_front.sv =====
// Byte parser: walks the CONNECT packet and raises a reply event when one is due.
`default_nettype none

module mcp_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire mcp_pkg::t_in  i_item,
    output logic               o_evt_push,
    output mcp_pkg::t_event    o_evt
);

    mcp_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_vcnt, n_vcnt;
    logic [7:0]  r_len_hi, n_len_hi;
    logic [15:0] r_left, n_left;
    logic        r_match, n_match;
    logic [7:0]  r_level, n_level;
    logic [7:0]  r_flags, n_flags;
    logic [15:0] r_ka, n_ka;
    logic [2:0]  r_str, n_str;

    logic [7:0]  b;
    logic [15:0] len;
    logic [2:0]  vcnt_inc;
    logic [1:0]  name_idx;
    logic [mcp_pkg::STR_COUNT-1:0] str_sel;
    logic        next_found;
    logic [2:0]  next_str;

    assign b        = i_item.data_byte;
    assign len      = {r_len_hi, b};
    assign vcnt_inc = r_vcnt + 3'd1;
    assign name_idx = 2'(~r_left[1:0] + 2'd1);

    // Strings in order: client id, will topic, will message, username, password.
    assign str_sel = {r_flags[6], r_flags[7], r_flags[2], r_flags[2], 1'b1};

    always_comb begin
        next_found = 1'b0;
        next_str   = '0;
        for (int t = mcp_pkg::STR_COUNT - 1; t >= 0; t--) begin
            if (str_sel[t] && (3'(t) > r_str)) begin
                next_found = 1'b1;
                next_str   = 3'(t);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= mcp_pkg::PH_IDLE;
            r_vcnt   <= '0;
            r_len_hi <= '0;
            r_left   <= '0;
            r_match  <= 1'b1;
            r_level  <= '0;
            r_flags  <= '0;
            r_ka     <= '0;
            r_str    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_vcnt   <= n_vcnt;
            r_len_hi <= n_len_hi;
            r_left   <= n_left;
            r_match  <= n_match;
            r_level  <= n_level;
            r_flags  <= n_flags;
            r_ka     <= n_ka;
            r_str    <= n_str;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_vcnt     = r_vcnt;
        n_len_hi   = r_len_hi;
        n_left     = r_left;
        n_match    = r_match;
        n_level    = r_level;
        n_flags    = r_flags;
        n_ka       = r_ka;
        n_str      = r_str;
        o_evt_push = 1'b0;
        o_evt.code       = mcp_pkg::CODE_ACCEPTED;
        o_evt.level      = r_level;
        o_evt.flags      = r_flags;
        o_evt.alive_secs = r_ka;

        if (i_accept) begin
            if (i_item.packet_start) begin
                n_vcnt   = '0;
                n_len_hi = '0;
                n_left   = '0;
                n_match  = 1'b1;
                n_level  = '0;
                n_flags  = '0;
                n_ka     = '0;
                n_str    = '0;
                n_phase  = (((b & mcp_pkg::TYPE_MASK) >> 4) == 8'(mcp_pkg::TYPE_CONNECT))
                         ? mcp_pkg::PH_VARINT : mcp_pkg::PH_IDLE;
            end else begin
                case (r_phase)
                    mcp_pkg::PH_VARINT: begin
                        n_vcnt = vcnt_inc;
                        if (!b[7] || (vcnt_inc >= mcp_pkg::VARINT_MAX)) begin
                            n_phase = mcp_pkg::PH_NAME_HI;
                        end
                    end
                    mcp_pkg::PH_NAME_HI: begin
                        n_len_hi = b;
                        n_phase  = mcp_pkg::PH_NAME_LO;
                    end
                    mcp_pkg::PH_NAME_LO: begin
                        n_left  = len;
                        n_match = (len == mcp_pkg::NAME_LEN);
                        if (len == '0) begin
                            // An empty name can never match.
                            o_evt_push = 1'b1;
                            o_evt.code = mcp_pkg::CODE_BAD_NAME;
                            n_phase    = mcp_pkg::PH_IDLE;
                        end else begin
                            n_phase = mcp_pkg::PH_NAME_BODY;
                        end
                    end
                    mcp_pkg::PH_NAME_BODY: begin
                        if (r_match && (r_left >= 16'd1) && (r_left <= mcp_pkg::NAME_LEN)
                            && (b != mcp_pkg::NAME_CHARS[name_idx])) begin
                            n_match = 1'b0;
                        end
                        n_left = r_left - 16'd1;
                        if (n_left == '0) begin
                            if (!n_match) begin
                                o_evt_push = 1'b1;
                                o_evt.code = mcp_pkg::CODE_BAD_NAME;
                                n_phase    = mcp_pkg::PH_IDLE;
                            end else begin
                                n_phase = mcp_pkg::PH_LEVEL;
                            end
                        end
                    end
                    mcp_pkg::PH_LEVEL: begin
                        n_level = b;
                        n_phase = mcp_pkg::PH_FLAGS;
                    end
                    mcp_pkg::PH_FLAGS: begin
                        n_flags = b;
                        n_phase = mcp_pkg::PH_KA_HI;
                    end
                    mcp_pkg::PH_KA_HI: begin
                        n_ka    = {b, 8'h00};
                        n_phase = mcp_pkg::PH_KA_LO;
                    end
                    mcp_pkg::PH_KA_LO: begin
                        n_ka    = r_ka | {8'h00, b};
                        n_str   = '0;
                        n_phase = mcp_pkg::PH_STR_HI;
                    end
                    mcp_pkg::PH_STR_HI: begin
                        n_len_hi = b;
                        n_phase  = mcp_pkg::PH_STR_LO;
                    end
                    mcp_pkg::PH_STR_LO, mcp_pkg::PH_STR_BODY: begin
                        n_left = (r_phase == mcp_pkg::PH_STR_LO) ? len : (r_left - 16'd1);
                        if (n_left == '0) begin
                            // String done: go to the next selected one or reply.
                            if (next_found && (r_str < mcp_pkg::STR_LAST)) begin
                                n_str   = next_str;
                                n_phase = mcp_pkg::PH_STR_HI;
                            end else begin
                                o_evt_push = 1'b1;
                                o_evt.code = mcp_pkg::CODE_ACCEPTED;
                                n_phase    = mcp_pkg::PH_IDLE;
                            end
                        end else begin
                            n_phase = mcp_pkg::PH_STR_BODY;
                        end
                    end
                    default: begin
                        n_phase = mcp_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mcp_evq.sv =====
// Two-entry queue of pending reply events between the parser and the serializer.
`default_nettype none

module mcp_evq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire mcp_pkg::t_event i_evt,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output mcp_pkg::t_event      o_evt
);

    mcp_pkg::t_event r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_evt   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mcp_back.sv =====
// Reply serializer: turns one event into the four CONNACK words.
`default_nettype none

module mcp_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_evt_valid,
    input  wire mcp_pkg::t_event i_evt,
    output logic                 o_evt_pop,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output mcp_pkg::t_out        o_result
);

    logic            r_busy;
    logic [1:0]      r_beat;
    mcp_pkg::t_event r_evt;
    logic            last_taken;

    assign o_empty    = !r_busy;
    assign last_taken = r_busy && i_pop && (r_beat == mcp_pkg::BEAT_LAST);
    // A new event loads when idle or as the last word of the current one leaves.
    assign o_evt_pop  = i_evt_valid && (!r_busy || last_taken);

    always_ff @(posedge i_clk) begin
        if (o_evt_pop) begin
            r_evt <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_beat <= '0;
        end else begin
            if (o_evt_pop) begin
                r_busy <= 1'b1;
                r_beat <= '0;
            end else if (last_taken) begin
                r_busy <= 1'b0;
                r_beat <= '0;
            end else if (r_busy && i_pop) begin
                r_beat <= r_beat + 2'd1;
            end
        end
    end

    always_comb begin
        case (r_beat)
            2'd0:    o_result.reply_byte = mcp_pkg::CONNACK_TYPE;
            2'd1:    o_result.reply_byte = mcp_pkg::CONNACK_LEN;
            2'd2:    o_result.reply_byte = mcp_pkg::CONNACK_RSVD;
            default: o_result.reply_byte = {7'b0, r_evt.code};
        endcase
        o_result.reply_last  = (r_beat == mcp_pkg::BEAT_LAST);
        o_result.return_code = r_evt.code;
        o_result.proto_lvl   = r_evt.level;
        o_result.flag_bits   = r_evt.flags;
        o_result.alive_secs  = r_evt.alive_secs;
    end

endmodule

`default_nettype wire

// ===== rtl/mqtt_connect_parser.sv =====
// Top level of the MQTT CONNECT parser with CONNACK reply.
//
// Input side is a queue write port: one packet byte per word, with
// packet_start set on the first byte of each packet. A word is taken when
// push is high and full is low: one byte every cycle while full stays low.
// Result side is a queue read port: while empty is low the oldest reply
// word is on o_result and pop takes it. Each reply is four words,
// 20 02 00 code, with the parsed level, flags and keep-alive on every word.
// The first reply word reaches o_result once the event for the byte ending
// the packet (or the protocol name, when the name is not MQTT) has passed
// through the event queue into the serializer; the four words then leave
// one per cycle while pop stays high.
// Between the parser and the serializer sits a two-entry event queue; full
// rises only when two replies wait there behind the one being read, so a
// stalled reader holds up the byte stream only after that.
// Reset clears the parse state to idle and empties both queues; bytes that
// arrive outside a CONNECT packet are taken and dropped.
`default_nettype none

module mqtt_connect_parser (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire mcp_pkg::t_in  i_item,
    output logic               empty,
    input  wire logic          pop,
    output mcp_pkg::t_out      o_result
);

    logic            accept;
    logic            evt_push;
    mcp_pkg::t_event evt_in;
    logic            evt_full;
    logic            evt_valid;
    mcp_pkg::t_event evt_out;
    logic            evt_pop;

    assign accept = push && !evt_full;
    assign full   = evt_full;

    mcp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .o_evt_push (evt_push),
        .o_evt      (evt_in)
    );

    mcp_evq u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (evt_push),
        .i_evt   (evt_in),
        .i_pop   (evt_pop),
        .o_full  (evt_full),
        .o_valid (evt_valid),
        .o_evt   (evt_out)
    );

    mcp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (evt_valid),
        .i_evt       (evt_out),
        .o_evt_pop   (evt_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

    // The parser only raises an event for a word it has taken.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        evt_full |-> !evt_push)
        else $error("reply event raised while event queue full");

    // A reply is never cut short: after a non-final word leaves, another follows.
    a_reply_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_result.reply_last) |=> !empty)
        else $error("reply ended before its final word");

    // Within one reply the return code does not change.
    a_code_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_result.reply_last) |=> $stable(o_result.return_code))
        else $error("return code changed inside a reply");

    // The final word carries the return code itself.
    a_last_is_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.reply_last) |->
            (o_result.reply_byte == {7'b0, o_result.return_code}))
        else $error("final reply word does not match the return code");

endmodule

`default_nettype wire
